// File: hw/rtl/cldr_pkg.sv
package cldr_pkg;

    localparam logic [1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [1:0] REQ_BIAS    = 2'd1;
    localparam logic [1:0] REQ_PIXEL   = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
    localparam logic [2:0] REG_IN_DEPTH    = 3'd2;
    localparam logic [2:0] REG_KERN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_KERN_WIDTH  = 3'd4;
    localparam logic [2:0] REG_PAD_WIDTH   = 3'd5;
    localparam logic [2:0] REG_STRIDE_STEP = 3'd6;
    localparam logic [2:0] REG_LEAK_SLOPE  = 3'd7;

    localparam int ACC_W    = 40;
    localparam int SCALED_W = 48;

    typedef struct packed {
        logic bias_load;
        logic rd_valid;
        logic act_mul;
        logic act_rnd;
    } dp_ctrl_t;

endpackage

// File: hw/rtl/cldr_req_if.sv
interface cldr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  kernel_sel;
    logic [1:0]  channel;
    logic [5:0]  row;
    logic [5:0]  col;
    logic signed [15:0] data_value;

    modport source (output valid, req_type, kernel_sel, channel, row, col, data_value,
                    input ready);
    modport sink (input valid, req_type, kernel_sel, channel, row, col, data_value,
                  output ready);
endinterface

// File: hw/rtl/cldr_rsp_if.sv
interface cldr_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] out_value;
    logic        error_flag;

    modport source (output valid, out_value, error_flag, input ready);
    modport sink (input valid, out_value, error_flag, output ready);
endinterface

// File: hw/rtl/cldr_cfg_if.sv
interface cldr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/cldr_ram.sv
module cldr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hw/rtl/cldr_mac.sv
module cldr_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  cldr_pkg::dp_ctrl_t ctrl,
    input  logic signed [15:0] bias_data,
    input  logic signed [15:0] img_data,
    input  logic signed [15:0] wgt_data,
    input  logic [7:0]         slope,
    output logic signed [15:0] result
);
    logic signed [31:0]                   prod_reg;
    logic                                 prod_valid_reg;
    logic signed [cldr_pkg::ACC_W-1:0]    acc_reg;
    logic signed [cldr_pkg::SCALED_W-1:0] scaled_reg;
    logic signed [cldr_pkg::SCALED_W-1:0] rounded;
    logic signed [cldr_pkg::SCALED_W-1:0] leak_prod;
    logic signed [8:0]                    slope_s;
    logic signed [15:0]                   result_reg;

    assign slope_s = $signed({1'b0, slope});
    assign leak_prod = cldr_pkg::SCALED_W'(acc_reg) * cldr_pkg::SCALED_W'(slope_s);
    // Q24.24 to Q8.8, ties toward plus infinity
    assign rounded = (scaled_reg + cldr_pkg::SCALED_W'(32768)) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_valid)
        begin
            prod_reg <= img_data * wgt_data;
        end
        if (ctrl.bias_load)
        begin
            acc_reg <= cldr_pkg::ACC_W'($signed({bias_data, 8'b0}));
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + cldr_pkg::ACC_W'(prod_reg);
        end
        if (ctrl.act_mul)
        begin
            if (acc_reg[cldr_pkg::ACC_W-1])
            begin
                scaled_reg <= leak_prod;
            end
            else
            begin
                scaled_reg <= cldr_pkg::SCALED_W'(acc_reg) <<< 8;
            end
        end
        if (ctrl.act_rnd)
        begin
            if (rounded > cldr_pkg::SCALED_W'(32767))
            begin
                result_reg <= 16'sh7FFF;
            end
            else if (rounded < -cldr_pkg::SCALED_W'(32768))
            begin
                result_reg <= -16'sh8000;
            end
            else
            begin
                result_reg <= rounded[15:0];
            end
        end
    end

    assign result = result_reg;
endmodule

// File: hw/rtl/conv2d_leaky_relu_engine_core.sv
// Channel  Dir  Moves                                         Accepted when
// req      in   req_type kernel_sel channel row col data_value valid && ready
// rsp      out  out_value error_flag                          valid && ready
// cfg      in   index data (register write)                   valid && ready
//
// Loads give no result; a rejected item gives one result. A compute steps through
// depth * kern_height * kern_width taps (196 taps max), with one shared
// multiply-accumulate per tap and one image and one weight memory read per
// cycle, and then loads its result into the output register.
// req.ready is high only while the sequencer is idle; one result may wait in
// the output register while the next item is taken, a second one stalls.
// Reset clears configuration to defaults and all control; stores are not cleared.
module conv2d_leaky_relu_engine_core #(
    parameter int MAX_HEIGHT     = 64,
    parameter int MAX_WIDTH      = 64,
    parameter int MAX_DEPTH      = 4,
    parameter int MAX_KERNEL_DIM = 7,
    parameter int MAX_KERNELS    = 16
) (
    input logic        clk,
    input logic        rst_n,
    cldr_req_if.sink   req,
    cldr_rsp_if.source rsp,
    cldr_cfg_if.sink   cfg
);
    localparam int HB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DB = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int TB = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
    localparam int KB = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int IMG_AW = DB + HB + WB;
    localparam int WGT_AW = KB + 2 * TB + DB;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_BIAS   = 4'd2;
    localparam logic [3:0] S_MAC    = 4'd3;
    localparam logic [3:0] S_DRAIN1 = 4'd4;
    localparam logic [3:0] S_DRAIN2 = 4'd5;
    localparam logic [3:0] S_ACT1   = 4'd6;
    localparam logic [3:0] S_ACT2   = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [6:0] in_height_reg, in_width_reg;
    logic [2:0] in_depth_reg, kern_height_reg, kern_width_reg, stride_step_reg;
    logic [1:0] pad_width_reg;
    logic [7:0] leak_slope_reg;

    logic [1:0]  type_reg;
    logic [3:0]  kernel_reg;
    logic [1:0]  chan_reg;
    logic [5:0]  row_reg, col_reg;
    logic [15:0] data_reg;

    logic [8:0] ybase_reg, xbase_reg;
    logic [2:0] z_reg, ky_reg, kx_reg;
    logic       err_reg;
    logic       rd_valid_reg;

    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_err_reg;

    logic [8:0]  pad_h, pad_w, ybase, xbase;
    logic        cfg_ok, weight_ok, bias_ok, pixel_ok, compute_ok, item_ok, k_ok;
    logic signed [10:0] py, px;
    logic        tap_in, tap_last;

    logic              img_we, wgt_we, bias_we;
    logic [IMG_AW-1:0] img_addr;
    logic [WGT_AW-1:0] wgt_addr;
    logic [15:0]       img_rdata, wgt_rdata, bias_rdata;
    logic signed [15:0] dp_result;
    cldr_pkg::dp_ctrl_t dp_ctrl;

    assign pad_h = 9'(in_height_reg) + 9'({pad_width_reg, 1'b0});
    assign pad_w = 9'(in_width_reg) + 9'({pad_width_reg, 1'b0});
    assign ybase = 9'(row_reg) * 9'(stride_step_reg);
    assign xbase = 9'(col_reg) * 9'(stride_step_reg);

    assign cfg_ok = (in_height_reg != 7'd0) && (32'(in_height_reg) <= MAX_HEIGHT)
                 && (in_width_reg != 7'd0) && (32'(in_width_reg) <= MAX_WIDTH)
                 && (in_depth_reg != 3'd0) && (32'(in_depth_reg) <= MAX_DEPTH)
                 && (kern_height_reg != 3'd0) && (32'(kern_height_reg) <= MAX_KERNEL_DIM)
                 && (kern_width_reg != 3'd0) && (32'(kern_width_reg) <= MAX_KERNEL_DIM)
                 && (stride_step_reg != 3'd0)
                 && (pad_h >= 9'(kern_height_reg)) && (pad_w >= 9'(kern_width_reg));

    assign k_ok = 32'(kernel_reg) < MAX_KERNELS;
    assign bias_ok = k_ok;
    assign weight_ok = k_ok && (in_depth_reg > 3'(chan_reg))
                    && (32'(chan_reg) < MAX_DEPTH)
                    && (6'(kern_height_reg) > row_reg) && (32'(row_reg) < MAX_KERNEL_DIM)
                    && (6'(kern_width_reg) > col_reg) && (32'(col_reg) < MAX_KERNEL_DIM);
    assign pixel_ok = (in_depth_reg > 3'(chan_reg)) && (32'(chan_reg) < MAX_DEPTH)
                   && (7'(row_reg) < in_height_reg) && (32'(row_reg) < MAX_HEIGHT)
                   && (7'(col_reg) < in_width_reg) && (32'(col_reg) < MAX_WIDTH);
    // r < out_rows holds exactly when r*stride + kern_height fits in the padded rows
    assign compute_ok = cfg_ok && k_ok
                     && (10'(ybase) + 10'(kern_height_reg) <= 10'(pad_h))
                     && (10'(xbase) + 10'(kern_width_reg) <= 10'(pad_w));

    always_comb
    begin
        case (type_reg)
            cldr_pkg::REQ_WEIGHT: item_ok = weight_ok;
            cldr_pkg::REQ_BIAS:   item_ok = bias_ok;
            cldr_pkg::REQ_PIXEL:  item_ok = pixel_ok;
            default:              item_ok = compute_ok;
        endcase
    end

    assign py = $signed(11'(ybase_reg) + 11'(ky_reg) - 11'(pad_width_reg));
    assign px = $signed(11'(xbase_reg) + 11'(kx_reg) - 11'(pad_width_reg));
    assign tap_in = !py[10] && !px[10]
                 && (py < $signed(11'(in_height_reg))) && (px < $signed(11'(in_width_reg)));
    assign tap_last = (kx_reg == kern_width_reg - 3'd1) && (ky_reg == kern_height_reg - 3'd1)
                   && (z_reg == in_depth_reg - 3'd1);

    assign img_we  = (state_reg == S_DECODE) && (type_reg == cldr_pkg::REQ_PIXEL) && pixel_ok;
    assign wgt_we  = (state_reg == S_DECODE) && (type_reg == cldr_pkg::REQ_WEIGHT) && weight_ok;
    assign bias_we = (state_reg == S_DECODE) && (type_reg == cldr_pkg::REQ_BIAS) && bias_ok;

    always_comb
    begin
        if (state_reg == S_MAC)
        begin
            img_addr = {DB'(z_reg), HB'(py), WB'(px)};
            wgt_addr = {KB'(kernel_reg), TB'(ky_reg), TB'(kx_reg), DB'(z_reg)};
        end
        else
        begin
            img_addr = {DB'(chan_reg), HB'(row_reg), WB'(col_reg)};
            wgt_addr = {KB'(kernel_reg), TB'(row_reg), TB'(col_reg), DB'(chan_reg)};
        end
    end

    cldr_ram #(.WIDTH(16), .DEPTH(2 ** IMG_AW)) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .addr  (img_addr),
        .wdata (data_reg),
        .rdata (img_rdata)
    );

    cldr_ram #(.WIDTH(16), .DEPTH(2 ** WGT_AW)) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .addr  (wgt_addr),
        .wdata (data_reg),
        .rdata (wgt_rdata)
    );

    cldr_ram #(.WIDTH(16), .DEPTH(2 ** KB)) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .addr  (KB'(kernel_reg)),
        .wdata (data_reg),
        .rdata (bias_rdata)
    );

    assign dp_ctrl.bias_load = (state_reg == S_BIAS);
    assign dp_ctrl.rd_valid  = rd_valid_reg;
    assign dp_ctrl.act_mul   = (state_reg == S_ACT1);
    assign dp_ctrl.act_rnd   = (state_reg == S_ACT2);

    cldr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .bias_data ($signed(bias_rdata)),
        .img_data  ($signed(img_rdata)),
        .wgt_data  ($signed(wgt_rdata)),
        .slope     (leak_slope_reg),
        .result    (dp_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!item_ok)
                begin
                    state_next = S_RESULT;
                end
                else if (type_reg == cldr_pkg::REQ_COMPUTE)
                begin
                    state_next = S_BIAS;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BIAS:   state_next = S_MAC;
            S_MAC:
            begin
                if (tap_last)
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = S_ACT1;
            S_ACT1:   state_next = S_ACT2;
            S_ACT2:   state_next = S_RESULT;
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            in_height_reg   <= 7'd32;
            in_width_reg    <= 7'd32;
            in_depth_reg    <= 3'd3;
            kern_height_reg <= 3'd3;
            kern_width_reg  <= 3'd3;
            pad_width_reg   <= 2'd0;
            stride_step_reg <= 3'd1;
            leak_slope_reg  <= 8'd3;
            out_valid_reg   <= 1'b0;
            rd_valid_reg    <= 1'b0;
            err_reg         <= 1'b0;
            z_reg           <= 3'd0;
            ky_reg          <= 3'd0;
            kx_reg          <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == S_MAC) && tap_in;

            if (cfg.valid)
            begin
                case (cfg.index)
                    cldr_pkg::REG_IN_HEIGHT:   in_height_reg   <= cfg.data[6:0];
                    cldr_pkg::REG_IN_WIDTH:    in_width_reg    <= cfg.data[6:0];
                    cldr_pkg::REG_IN_DEPTH:    in_depth_reg    <= cfg.data[2:0];
                    cldr_pkg::REG_KERN_HEIGHT: kern_height_reg <= cfg.data[2:0];
                    cldr_pkg::REG_KERN_WIDTH:  kern_width_reg  <= cfg.data[2:0];
                    cldr_pkg::REG_PAD_WIDTH:   pad_width_reg   <= cfg.data[1:0];
                    cldr_pkg::REG_STRIDE_STEP: stride_step_reg <= cfg.data[2:0];
                    cldr_pkg::REG_LEAK_SLOPE:  leak_slope_reg  <= cfg.data;
                    default:                   ;
                endcase
            end

            if (state_reg == S_DECODE)
            begin
                err_reg <= !item_ok;
                z_reg   <= 3'd0;
                ky_reg  <= 3'd0;
                kx_reg  <= 3'd0;
            end

            // advance the tap counters, column fastest
            if (state_reg == S_MAC)
            begin
                if (kx_reg == kern_width_reg - 3'd1)
                begin
                    kx_reg <= 3'd0;
                    if (ky_reg == kern_height_reg - 3'd1)
                    begin
                        ky_reg <= 3'd0;
                        z_reg  <= z_reg + 3'd1;
                    end
                    else
                    begin
                        ky_reg <= ky_reg + 3'd1;
                    end
                end
                else
                begin
                    kx_reg <= kx_reg + 3'd1;
                end
            end

            if ((state_reg == S_RESULT) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            type_reg   <= req.req_type;
            kernel_reg <= req.kernel_sel;
            chan_reg   <= req.channel;
            row_reg    <= req.row;
            col_reg    <= req.col;
            data_reg   <= req.data_value;
        end
        if (state_reg == S_DECODE)
        begin
            ybase_reg <= ybase;
            xbase_reg <= xbase;
        end
        if ((state_reg == S_RESULT) && (!out_valid_reg || rsp.ready))
        begin
            out_value_reg <= err_reg ? 16'd0 : dp_result;
            out_err_reg   <= err_reg;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.out_value  = out_value_reg;
    assign rsp.error_flag = out_err_reg;

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    a_read_from_mac: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == S_MAC))
        else $error("tap read outside accumulate phase");

    a_tap_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |->
            (kx_reg < kern_width_reg) && (ky_reg < kern_height_reg) && (z_reg < in_depth_reg))
        else $error("tap counter out of kernel");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_value_reg == 16'd0))
        else $error("rejected item with nonzero value");

    a_no_write_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> !(img_we || wgt_we || bias_we))
        else $error("store written during accumulate");
endmodule

// File: tb/sv/conv2d_leaky_relu_engine_core_tb.sv
module conv2d_leaky_relu_engine_core_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_MISMATCH_PRINT = 10;

    typedef struct {
        logic signed [15:0] value;
        logic               err;
    } conv_result_t;

    // Scoreboard: owns the predicted stores and configuration.
    class conv_scoreboard;
        logic signed [15:0] image_mem [0:3][0:63][0:63];
        logic signed [15:0] weight_mem [0:15][0:6][0:6][0:3];
        logic signed [15:0] bias_mem [0:15];
        int unsigned in_height, in_width, in_depth, kern_height, kern_width;
        int unsigned pad_width, stride_step, leak_slope;
        conv_result_t pending_q[$];
        int mismatches;

        function void reset_config();
            in_height = 32; in_width = 32; in_depth = 3;
            kern_height = 3; kern_width = 3;
            pad_width = 0; stride_step = 1; leak_slope = 3;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                cldr_pkg::REG_IN_HEIGHT:   in_height   = data[6:0];
                cldr_pkg::REG_IN_WIDTH:    in_width    = data[6:0];
                cldr_pkg::REG_IN_DEPTH:    in_depth    = data[2:0];
                cldr_pkg::REG_KERN_HEIGHT: kern_height = data[2:0];
                cldr_pkg::REG_KERN_WIDTH:  kern_width  = data[2:0];
                cldr_pkg::REG_PAD_WIDTH:   pad_width   = data[1:0];
                cldr_pkg::REG_STRIDE_STEP: stride_step = data[2:0];
                cldr_pkg::REG_LEAK_SLOPE:  leak_slope  = data;
                default: ;
            endcase
        endfunction

        function bit config_ok();
            if (in_height < 1 || in_height > 64 || in_width < 1 || in_width > 64) return 0;
            if (in_depth < 1 || in_depth > 4) return 0;
            if (kern_height < 1 || kern_width < 1 || stride_step < 1) return 0;
            if (in_height + 2 * pad_width < kern_height) return 0;
            if (in_width + 2 * pad_width < kern_width) return 0;
            return 1;
        endfunction

        function int unsigned out_rows();
            return (in_height + 2 * pad_width - kern_height) / stride_step + 1;
        endfunction

        function int unsigned out_cols();
            return (in_width + 2 * pad_width - kern_width) / stride_step + 1;
        endfunction

        function void add_expected(conv_result_t r);
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void push_reject();
            conv_result_t r;
            r.value = '0;
            r.err = 1'b1;
            add_expected(r);
        endfunction

        function void note_request(logic [1:0] rt, logic [3:0] k, logic [1:0] ch,
                                   logic [5:0] r, logic [5:0] c, logic signed [15:0] d);
            longint acc, scaled, t, res;
            int py, px;
            conv_result_t o;
            case (rt)
                cldr_pkg::REQ_WEIGHT:
                    if (ch < in_depth && r < kern_height && c < kern_width)
                        weight_mem[k][r][c][ch] = d;
                    else
                        push_reject();
                cldr_pkg::REQ_BIAS:
                    bias_mem[k] = d;
                cldr_pkg::REQ_PIXEL:
                    if (ch < in_depth && r < in_height && c < in_width)
                        image_mem[ch][r][c] = d;
                    else
                        push_reject();
                default:
                    if (!config_ok() || r >= out_rows() || c >= out_cols())
                        push_reject();
                    else
                    begin
                        acc = longint'(bias_mem[k]) * 256;
                        for (int z = 0; z < in_depth; z++)
                            for (int ky = 0; ky < kern_height; ky++)
                                for (int kx = 0; kx < kern_width; kx++)
                                begin
                                    py = r * stride_step + ky - pad_width;
                                    px = c * stride_step + kx - pad_width;
                                    if (py >= 0 && px >= 0 && py < in_height && px < in_width)
                                        acc += longint'(image_mem[z][py][px]) *
                                               longint'(weight_mem[k][ky][kx][z]);
                                end
                        scaled = (acc >= 0) ? acc * 256 : acc * longint'(leak_slope);
                        t = scaled * 256 + (longint'(1) << 23);
                        res = t >>> 24;
                        if (res > 32767) res = 32767;
                        if (res < -32768) res = -32768;
                        o.value = res[15:0];
                        o.err = 1'b0;
                        add_expected(o);
                    end
            endcase
        endfunction

        function void check_result(logic signed [15:0] v, logic e);
            conv_result_t x;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_MISMATCH_PRINT)
                    $display("unexpected result value=%0d err=%0b", v, e);
                return;
            end
            x = pending_q.pop_front();
            if (x.value !== v || x.err !== e)
            begin
                mismatches++;
                if (mismatches <= MAX_MISMATCH_PRINT)
                    $display("result mismatch: expected value=%0d err=%0b, got value=%0d err=%0b",
                             x.value, x.err, v, e);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    cldr_req_if req ();
    cldr_rsp_if rsp ();
    cldr_cfg_if cfg ();

    conv2d_leaky_relu_engine_core DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    conv_scoreboard sb;
    bit quiet_phase;
    bit long_hold;
    int idle_cycles;

    // bookkeeping of which pixel, weight and bias entries have been written
    bit pix_written [0:3][0:63][0:63];
    bit wgt_written [0:15][0:6][0:6][0:3];
    bit bias_written [0:15];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_cfg(logic [2:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_req(logic [1:0] rt, logic [3:0] k, logic [1:0] ch,
                            logic [5:0] r, logic [5:0] c, logic [15:0] d);
        int gap;
        @(negedge clk);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= rt;
        req.kernel_sel <= k;
        req.channel    <= ch;
        req.row        <= r;
        req.col        <= c;
        req.data_value <= d;
        do @(posedge clk); while (!req.ready);
        sb.note_request(rt, k, ch, r, c, d);
        if (rt == cldr_pkg::REQ_WEIGHT && ch < sb.in_depth && r < sb.kern_height
            && c < sb.kern_width)
            wgt_written[k][r][c][ch] = 1;
        if (rt == cldr_pkg::REQ_BIAS)
            bias_written[k] = 1;
        if (rt == cldr_pkg::REQ_PIXEL && ch < sb.in_depth && r < sb.in_height
            && c < sb.in_width)
            pix_written[ch][r][c] = 1;
    endtask

    task automatic release_req();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    // Compute is legal to issue only if it will be rejected or every store entry it would read is written.
    function automatic bit compute_safe(int k, int r, int c);
        int py, px;
        if (!sb.config_ok() || r >= sb.out_rows() || c >= sb.out_cols())
            return 1;
        if (!bias_written[k])
            return 0;
        for (int z = 0; z < sb.in_depth; z++)
            for (int ky = 0; ky < sb.kern_height; ky++)
                for (int kx = 0; kx < sb.kern_width; kx++)
                begin
                    py = r * sb.stride_step + ky - sb.pad_width;
                    px = c * sb.stride_step + kx - sb.pad_width;
                    if (py >= 0 && px >= 0 && py < sb.in_height && px < sb.in_width)
                        if (!pix_written[z][py][px] || !wgt_written[k][ky][kx][z])
                            return 0;
                end
        return 1;
    endfunction

    function automatic logic [15:0] rand_data();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom());
        endcase
    endfunction

    // Fill the image and the first nk kernels under the current configuration.
    task automatic load_layer(int nk);
        for (int k = 0; k < nk; k++)
        begin
            send_req(cldr_pkg::REQ_BIAS, 4'(k), 2'($urandom()), 6'($urandom()),
                     6'($urandom()), rand_data());
            for (int z = 0; z < sb.in_depth; z++)
                for (int ky = 0; ky < sb.kern_height; ky++)
                    for (int kx = 0; kx < sb.kern_width; kx++)
                        send_req(cldr_pkg::REQ_WEIGHT, 4'(k), 2'(z), 6'(ky), 6'(kx),
                                 rand_data());
        end
        for (int z = 0; z < sb.in_depth; z++)
            for (int y = 0; y < sb.in_height; y++)
                for (int x = 0; x < sb.in_width; x++)
                    send_req(cldr_pkg::REQ_PIXEL, 4'($urandom()), 2'(z), 6'(y), 6'(x),
                             rand_data());
    endtask

    task automatic random_items(int n, int nk);
        int k, r, c, sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 9);
            k = $urandom_range(0, nk - 1);
            if (sel < 7)
            begin
                r = $urandom_range(0, sb.out_rows());
                c = $urandom_range(0, sb.out_cols());
                if (sel == 0)
                begin
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                end
                if (compute_safe(k, r, c))
                    send_req(cldr_pkg::REQ_COMPUTE, 4'(k), 2'($urandom()), 6'(r), 6'(c),
                             16'($urandom()));
            end
            else if (sel == 7)
                send_req(cldr_pkg::REQ_WEIGHT, 4'(k), 2'($urandom()), 6'($urandom_range(0, 8)),
                         6'($urandom_range(0, 8)), rand_data());
            else if (sel == 8)
                send_req(cldr_pkg::REQ_PIXEL, 4'($urandom()), 2'($urandom()), 6'($urandom()),
                         6'($urandom()), rand_data());
            else
                send_req(cldr_pkg::REQ_BIAS, 4'(k), 2'($urandom()), 6'($urandom()),
                         6'($urandom()), rand_data());
        end
        release_req();
    endtask

    // Drain, then let a trailing compute finish before touching registers.
    task automatic wait_idle();
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (220) @(posedge clk);
    endtask

    task automatic set_shape(int h, int w, int d, int kh, int kw, int p, int s, int slope);
        send_cfg(cldr_pkg::REG_IN_HEIGHT, 8'(h));
        send_cfg(cldr_pkg::REG_IN_WIDTH, 8'(w));
        send_cfg(cldr_pkg::REG_IN_DEPTH, 8'(d));
        send_cfg(cldr_pkg::REG_KERN_HEIGHT, 8'(kh));
        send_cfg(cldr_pkg::REG_KERN_WIDTH, 8'(kw));
        send_cfg(cldr_pkg::REG_PAD_WIDTH, 8'(p));
        send_cfg(cldr_pkg::REG_STRIDE_STEP, 8'(s));
        send_cfg(cldr_pkg::REG_LEAK_SLOPE, 8'(slope));
    endtask

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        int burst;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (600) @(negedge clk);
                long_hold = 0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 5);
                rsp.ready <= 1'b0;
                repeat (burst) @(negedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.out_value, rsp.error_flag);

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.reset_config();
        idle_cycles = 0;
        quiet_phase = 0;
        long_hold = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = cldr_pkg::REQ_WEIGHT;
        req.kernel_sel = '0;
        req.channel = '0;
        req.row = '0;
        req.col = '0;
        req.data_value = '0;
        cfg.valid = 1'b0;
        cfg.index = cldr_pkg::REG_IN_HEIGHT;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: small image, extremes of data, every request kind and rejection.
        set_shape(3, 3, 1, 2, 2, 1, 1, 0);
        send_req(cldr_pkg::REQ_BIAS, 4'd15, 2'd3, 6'd63, 6'd63, 16'h7FFF);
        send_req(cldr_pkg::REQ_BIAS, 4'd0, 2'd0, 6'd0, 6'd0, 16'h8000);
        for (int ky = 0; ky < 2; ky++)
            for (int kx = 0; kx < 2; kx++)
            begin
                send_req(cldr_pkg::REQ_WEIGHT, 4'd0, 2'd0, 6'(ky), 6'(kx), 16'h7FFF);
                send_req(cldr_pkg::REQ_WEIGHT, 4'd15, 2'd0, 6'(ky), 6'(kx), 16'h8000);
            end
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_req(cldr_pkg::REQ_PIXEL, 4'd0, 2'd0, 6'(y), 6'(x),
                         (x == 1) ? 16'h8000 : 16'h7FFF);
        send_req(cldr_pkg::REQ_WEIGHT, 4'd3, 2'd1, 6'd0, 6'd0, 16'h1234);   // channel beyond depth
        send_req(cldr_pkg::REQ_WEIGHT, 4'd3, 2'd0, 6'd2, 6'd0, 16'h1234);   // tap row beyond kernel
        send_req(cldr_pkg::REQ_PIXEL, 4'd0, 2'd0, 6'd63, 6'd0, 16'h0100);   // row beyond image
        send_req(cldr_pkg::REQ_COMPUTE, 4'd0, 2'd0, 6'd0, 6'd0, 16'h0);
        send_req(cldr_pkg::REQ_COMPUTE, 4'd15, 2'd3, 6'd3, 6'd3, 16'h0);    // last window with padding
        send_req(cldr_pkg::REQ_COMPUTE, 4'd0, 2'd0, 6'd4, 6'd0, 16'h0);     // outside grid
        send_req(cldr_pkg::REQ_COMPUTE, 4'd0, 2'd0, 6'd63, 6'd63, 16'hFFFF);
        release_req();
        wait_idle();

        // Bad configuration: kernel larger than padded image, then zero stride, then zero depth and oversized height.
        send_cfg(cldr_pkg::REG_KERN_HEIGHT, 8'd7);
        send_req(cldr_pkg::REQ_COMPUTE, 4'd0, 2'd0, 6'd0, 6'd0, 16'h0);
        release_req();
        wait_idle();
        send_cfg(cldr_pkg::REG_KERN_HEIGHT, 8'd2);
        send_cfg(cldr_pkg::REG_STRIDE_STEP, 8'd0);
        send_req(cldr_pkg::REQ_COMPUTE, 4'd0, 2'd0, 6'd0, 6'd0, 16'h0);
        release_req();
        wait_idle();
        send_cfg(cldr_pkg::REG_IN_DEPTH, 8'd0);
        send_cfg(cldr_pkg::REG_IN_HEIGHT, 8'd127);
        send_req(cldr_pkg::REQ_COMPUTE, 4'd0, 2'd0, 6'd0, 6'd0, 16'h0);
        release_req();
        wait_idle();

        // Random phases across settings.
        set_shape(5, 6, 2, 3, 2, 1, 2, 128);
        load_layer(3);
        random_items(60, 3);
        wait_idle();

        set_shape(4, 4, 4, 3, 3, 0, 1, 255);
        load_layer(1);
        long_hold = 1;
        random_items(60, 1);
        wait_idle();

        set_shape(64, 1, 1, 7, 1, 3, 7, 17);
        load_layer(1);
        random_items(40, 1);
        wait_idle();

        set_shape(2, 3, 3, 7, 7, 3, 3, 64);
        load_layer(1);
        random_items(40, 1);
        wait_idle();

        set_shape(1, 64, 1, 1, 1, 0, 1, 3);
        load_layer(1);
        quiet_phase = 1;
        random_items(60, 1);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (220) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
